FILE: rtl/core/adsr_pkg.sv
package adsr_pkg;

  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 15;
  localparam logic [GAIN_W-1:0] FULL_GAIN = 16'h8000;

  typedef enum logic [2:0] {
    PH_ATTACK  = 3'd0,
    PH_DECAY   = 3'd1,
    PH_SUSTAIN = 3'd2,
    PH_RELEASE = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    REG_ATTACK  = 2'd0,
    REG_DECAY   = 2'd1,
    REG_SUSTAIN = 2'd2,
    REG_RELEASE = 2'd3
  } reg_index_t;

endpackage

FILE: rtl/core/adsr_div_cell.sv
module adsr_div_cell #(
  parameter int W  = 24,
  parameter int NB = 15,
  parameter int SW = 37
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [W-1:0]  d_in,
  input  logic [W-1:0]  rem_in,
  input  logic [NB-1:0] num_in,
  input  logic [NB-1:0] q_in,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [W-1:0]  d_out,
  output logic [W-1:0]  rem_out,
  output logic [NB-1:0] num_out,
  output logic [NB-1:0] q_out,
  output logic [SW-1:0] side_out
);

  logic [W:0] trial;
  logic [W:0] diff;
  logic       ge;

  assign trial    = {rem_in, num_in[NB-1]};
  assign ge       = trial >= {1'b0, d_in};
  assign diff     = trial - {1'b0, d_in};
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      d_out    <= d_in;
      rem_out  <= ge ? diff[W-1:0] : trial[W-1:0];
      num_out  <= {num_in[NB-2:0], 1'b0};
      q_out    <= {q_in[NB-2:0], ge};
      side_out <= side_in;
    end
  end

endmodule

FILE: rtl/core/adsr_phase_sel.sv
module adsr_phase_sel #(
  parameter int TICK_BITS = 24
) (
  input  logic [TICK_BITS-1:0]      attack_len,
  input  logic [TICK_BITS-1:0]      decay_len,
  input  logic [15:0]               sustain_level,
  input  logic [TICK_BITS-1:0]      release_len,
  input  logic                      gate_on,
  input  logic [TICK_BITS-1:0]      since_on,
  input  logic [TICK_BITS-1:0]      since_release,
  output logic [TICK_BITS-1:0]      x,
  output logic [TICK_BITS-1:0]      d,
  output logic [15:0]               m,
  output logic [15:0]               base,
  output logic                      neg,
  output adsr_pkg::phase_t          phase
);

  logic [15:0]          sus;
  logic [TICK_BITS:0]   ad_sum;
  logic [TICK_BITS-1:0] one;

  assign sus    = (sustain_level > adsr_pkg::FULL_GAIN) ? adsr_pkg::FULL_GAIN : sustain_level;
  assign ad_sum = {1'b0, attack_len} + {1'b0, decay_len};
  assign one    = {{(TICK_BITS-1){1'b0}}, 1'b1};

  always_comb begin
    x     = '0;
    d     = one;
    m     = '0;
    base  = '0;
    neg   = 1'b0;
    phase = adsr_pkg::PH_DONE;
    if (gate_on && since_on < attack_len) begin
      x     = since_on;
      d     = attack_len;
      m     = adsr_pkg::FULL_GAIN;
      phase = adsr_pkg::PH_ATTACK;
    end else if (gate_on && {1'b0, since_on} < ad_sum) begin
      x     = since_on - attack_len;
      d     = decay_len;
      m     = adsr_pkg::FULL_GAIN - sus;
      base  = adsr_pkg::FULL_GAIN;
      neg   = 1'b1;
      phase = adsr_pkg::PH_DECAY;
    end else if (gate_on) begin
      base  = sus;
      phase = adsr_pkg::PH_SUSTAIN;
    end else if (since_release < release_len) begin
      x     = since_release;
      d     = release_len;
      m     = sus;
      base  = sus;
      neg   = 1'b1;
      phase = adsr_pkg::PH_RELEASE;
    end
  end

endmodule

FILE: rtl/core/adsr_envelope_gain_core.sv
// Pipeline: 20 register stages from input acceptance to the result register.
// Throughput: one transaction per cycle while out_stall stays low; the
// restoring divider is a row of 15 cells, one quotient bit each, so every
// stage takes a new item each cycle unless held. Each stage holds on its own
// when its successor is full, so bubbles close up. Reset (rst, synchronous,
// active high) clears all valids and the configuration registers only.
module adsr_envelope_gain_core #(
  parameter int SAMPLE_BITS = 16,
  parameter int TICK_BITS   = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [TICK_BITS-1:0]          cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic                          gate_on,
  input  logic [TICK_BITS-1:0]          since_on,
  input  logic [TICK_BITS-1:0]          since_release,
  input  logic                          block_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic [15:0]                   gain,
  output logic [2:0]                    phase,
  output logic                          block_end_out
);

  localparam int QW = adsr_pkg::GAIN_FRAC;
  localparam int SW = SAMPLE_BITS + 21;
  localparam int PW = TICK_BITS + 16;

  logic [TICK_BITS-1:0] attack_len;
  logic [TICK_BITS-1:0] decay_len;
  logic [15:0]          sustain_level;
  logic [TICK_BITS-1:0] release_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_len    <= '0;
      decay_len     <= '0;
      sustain_level <= '0;
      release_len   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        adsr_pkg::REG_ATTACK:  attack_len    <= cfg_data;
        adsr_pkg::REG_DECAY:   decay_len     <= cfg_data;
        adsr_pkg::REG_SUSTAIN: sustain_level <= cfg_data[15:0];
        adsr_pkg::REG_RELEASE: release_len   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [TICK_BITS-1:0] sel_x;
  logic [TICK_BITS-1:0] sel_d;
  logic [15:0]          sel_m;
  logic [15:0]          sel_base;
  logic                 sel_neg;
  adsr_pkg::phase_t     sel_phase;

  adsr_phase_sel #(.TICK_BITS(TICK_BITS)) u_sel (
    .attack_len    (attack_len),
    .decay_len     (decay_len),
    .sustain_level (sustain_level),
    .release_len   (release_len),
    .gate_on       (gate_on),
    .since_on      (since_on),
    .since_release (since_release),
    .x             (sel_x),
    .d             (sel_d),
    .m             (sel_m),
    .base          (sel_base),
    .neg           (sel_neg),
    .phase         (sel_phase)
  );

  logic rdy0;
  logic rdy1;
  logic rdy2;
  logic rdy3;
  logic rdy_o;

  logic                 v0;
  logic [TICK_BITS-1:0] x0;
  logic [TICK_BITS-1:0] d0;
  logic [15:0]          m0;
  logic [SW-1:0]        side0;

  logic                 v1;
  logic [PW-1:0]        n1;
  logic [TICK_BITS-1:0] d1;
  logic [SW-1:0]        side1;

  logic                 c_valid [QW+1];
  logic                 c_rdy   [QW+1];
  logic [TICK_BITS-1:0] c_d     [QW+1];
  logic [TICK_BITS-1:0] c_rem   [QW+1];
  logic [QW-1:0]        c_num   [QW+1];
  logic [QW-1:0]        c_q     [QW+1];
  logic [SW-1:0]        c_side  [QW+1];

  assign in_stall = !rdy0;
  assign rdy0     = !v0 || rdy1;
  assign rdy1     = !v1 || c_rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      if (rdy0) v0 <= in_valid;
      if (rdy1) v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      x0    <= sel_x;
      d0    <= sel_d;
      m0    <= sel_m;
      side0 <= {sample_in, block_end, sel_phase, sel_base, sel_neg};
    end
    if (rdy1 && v0) begin
      n1    <= PW'(x0 * m0);
      d1    <= d0;
      side1 <= side0;
    end
  end

  assign c_valid[0] = v1;
  assign c_d[0]     = d1;
  assign c_rem[0]   = n1[TICK_BITS+QW-1:QW];
  assign c_num[0]   = n1[QW-1:0];
  assign c_q[0]     = '0;
  assign c_side[0]  = side1;
  assign c_rdy[QW]  = rdy2;

  for (genvar k = 0; k < QW; k++) begin : g_cell
    adsr_div_cell #(.W(TICK_BITS), .NB(QW), .SW(SW)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (c_valid[k]),
      .in_ready  (c_rdy[k]),
      .d_in      (c_d[k]),
      .rem_in    (c_rem[k]),
      .num_in    (c_num[k]),
      .q_in      (c_q[k]),
      .side_in   (c_side[k]),
      .out_valid (c_valid[k+1]),
      .out_ready (c_rdy[k+1]),
      .d_out     (c_d[k+1]),
      .rem_out   (c_rem[k+1]),
      .num_out   (c_num[k+1]),
      .q_out     (c_q[k+1]),
      .side_out  (c_side[k+1])
    );
  end

  logic [SAMPLE_BITS-1:0] e_sample;
  logic                   e_be;
  logic [2:0]             e_phase;
  logic [15:0]            e_base;
  logic                   e_neg;
  logic [15:0]            e_q;

  assign {e_sample, e_be, e_phase, e_base, e_neg} = c_side[QW];
  assign e_q = {1'b0, c_q[QW]};

  logic                   v2;
  logic [15:0]            g2;
  logic [SAMPLE_BITS-1:0] s2;
  logic                   be2;
  logic [2:0]             ph2;

  logic                    v3;
  logic [SAMPLE_BITS+15:0] p3;
  logic                    neg3;
  logic [15:0]             g3;
  logic                    be3;
  logic [2:0]              ph3;

  logic [SAMPLE_BITS-1:0] mag2;
  logic [SAMPLE_BITS:0]   pr3;
  logic [SAMPLE_BITS:0]   res3;

  assign rdy2  = !v2 || rdy3;
  assign rdy3  = !v3 || rdy_o;
  assign rdy_o = !out_valid || !out_stall;

  assign mag2 = s2[SAMPLE_BITS-1] ? (~s2 + 1'b1) : s2;
  assign pr3  = p3[SAMPLE_BITS+15:QW];
  assign res3 = neg3 ? (~pr3 + 1'b1) : pr3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy2)  v2        <= c_valid[QW];
      if (rdy3)  v3        <= v2;
      if (rdy_o) out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && c_valid[QW]) begin
      g2  <= e_neg ? (e_base - e_q) : (e_base + e_q);
      s2  <= e_sample;
      be2 <= e_be;
      ph2 <= e_phase;
    end
    if (rdy3 && v2) begin
      p3   <= (SAMPLE_BITS+16)'(mag2 * g2);
      neg3 <= s2[SAMPLE_BITS-1];
      g3   <= g2;
      be3  <= be2;
      ph3  <= ph2;
    end
    if (rdy_o && v3) begin
      sample_out    <= res3[SAMPLE_BITS-1:0];
      gain          <= g3;
      phase         <= ph3;
      block_end_out <= be3;
    end
  end

endmodule

FILE: rtl/core/adsr_checker.sv
module adsr_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] sample_out,
  input logic [15:0]                   gain,
  input logic [2:0]                    phase
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample_out) && $stable(gain))
    else $error("stalled result changed");

  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> gain <= adsr_pkg::FULL_GAIN)
    else $error("gain above full scale");

  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    out_valid && phase == adsr_pkg::PH_DONE |-> gain == 16'd0 && sample_out == '0)
    else $error("finished phase not silent");

endmodule

bind adsr_envelope_gain_core adsr_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_adsr_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .sample_out (sample_out),
  .gain       (gain),
  .phase      (phase)
);

FILE: bench/tb_adsr_envelope_gain_core.sv
module tb_adsr_envelope_gain_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB = 16;
  localparam int TB = 24;
  localparam int LATENCY = 20;
  localparam longint CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic signed [SB-1:0] smp;
    logic                 gate;
    logic [TB-1:0]        on_t;
    logic [TB-1:0]        rel_t;
    logic                 bend;
  } note_in_t;

  typedef struct packed {
    logic signed [SB-1:0] smp;
    logic [15:0]          g;
    logic [2:0]           ph;
    logic                 bend;
  } gain_out_t;

  typedef struct {
    note_in_t  stim;
    logic      known;
    gain_out_t res;
  } dir_row_t;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = adsr_pkg::REG_ATTACK;
  logic [TB-1:0] cfg_data = '0;
  logic in_valid = 0, in_stall;
  logic signed [SB-1:0] sample_in = '0;
  logic gate_on = 0;
  logic [TB-1:0] since_on = '0, since_release = '0;
  logic block_end = 0;
  logic out_valid, out_stall = 0;
  logic signed [SB-1:0] sample_out;
  logic [15:0] gain;
  logic [2:0] phase;
  logic block_end_out;

  adsr_envelope_gain_core #(.SAMPLE_BITS(SB), .TICK_BITS(TB)) dut (.*);

  logic [TB-1:0] atk_len, dec_len, rel_len;
  logic [15:0] sus_reg;
  gain_out_t pending_gain[$];
  int errors = 0;
  longint cycles = 0;
  int send_idle = 0, recv_idle = 0;
  bit hold_off = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic gain_out_t envelope_gain(note_in_t n);
    gain_out_t r;
    longint unsigned s, gn, d, mag, prod;
    s = (sus_reg > 16'h8000) ? 32768 : sus_reg;
    if (n.gate && n.on_t < atk_len) begin
      r.ph = adsr_pkg::PH_ATTACK;
      gn = (longint'(n.on_t) * 32768) / atk_len;
    end else if (n.gate && longint'(n.on_t) < longint'(atk_len) + dec_len) begin
      d = n.on_t - atk_len;
      r.ph = adsr_pkg::PH_DECAY;
      gn = 32768 - ((32768 - s) * d) / dec_len;
    end else if (n.gate) begin
      r.ph = adsr_pkg::PH_SUSTAIN;
      gn = s;
    end else if (n.rel_t < rel_len) begin
      r.ph = adsr_pkg::PH_RELEASE;
      gn = s - (s * n.rel_t) / rel_len;
    end else begin
      r.ph = adsr_pkg::PH_DONE;
      gn = 0;
    end
    mag = n.smp[SB-1] ? longint'(-longint'(n.smp)) : longint'(n.smp);
    prod = (mag * gn) >> 15;
    r.smp = n.smp[SB-1] ? SB'(-prod) : SB'(prod);
    r.g = gn[15:0];
    r.bend = n.bend;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    gain_out_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_gain.size() == 0) report_mismatch("unexpected transaction", 1, 0);
      else begin
        e = pending_gain.pop_front();
        if (sample_out !== e.smp) report_mismatch("sample_out", sample_out, e.smp);
        if (gain !== e.g) report_mismatch("gain", gain, e.g);
        if (phase !== e.ph) report_mismatch("phase", phase, e.ph);
        if (block_end_out !== e.bend) report_mismatch("block_end_out", block_end_out, e.bend);
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off) out_stall <= 1;
    else out_stall <= ($urandom_range(99) < recv_idle);
  end

  task automatic drop_input();
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic write_reg(adsr_pkg::reg_index_t idx, logic [TB-1:0] v);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      adsr_pkg::REG_ATTACK:  atk_len = v;
      adsr_pkg::REG_DECAY:   dec_len = v;
      adsr_pkg::REG_SUSTAIN: sus_reg = v[15:0];
      adsr_pkg::REG_RELEASE: rel_len = v;
      default: ;
    endcase
  endtask

  task automatic set_envelope(logic [TB-1:0] a, logic [TB-1:0] d, logic [15:0] s,
                              logic [TB-1:0] r);
    drop_input();
    while (pending_gain.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    write_reg(adsr_pkg::REG_ATTACK, a);
    write_reg(adsr_pkg::REG_DECAY, d);
    write_reg(adsr_pkg::REG_SUSTAIN, {8'h0, s});
    write_reg(adsr_pkg::REG_RELEASE, r);
  endtask

  // drive at negedge, hold until accepted at posedge
  task automatic send_note(note_in_t n, gain_out_t want, bit known);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    sample_in <= n.smp;
    gate_on <= n.gate;
    since_on <= n.on_t;
    since_release <= n.rel_t;
    block_end <= n.bend;
    pending_gain.push_back(known ? want : envelope_gain(n));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [TB-1:0] rand_len();
    case ($urandom_range(5))
      0: return '0;
      1: return 24'hFFFFFF;
      2: return TB'($urandom_range(1, 4));
      default: return TB'($urandom_range(1, 3000));
    endcase
  endfunction

  function automatic note_in_t rand_note();
    note_in_t n;
    int span;
    span = atk_len + dec_len + 8;
    n.smp = SB'($urandom);
    n.gate = 1'($urandom_range(1));
    n.on_t = ($urandom_range(9) == 0) ? TB'($urandom) : TB'($urandom_range(span + 50));
    n.rel_t = ($urandom_range(9) == 0) ? TB'($urandom) : TB'($urandom_range(rel_len + 50));
    n.bend = 1'($urandom_range(1));
    return n;
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) send_note(rand_note(), '0, 0);
  endtask

  dir_row_t dir_rows[] = '{
    '{'{16'sh7FFF, 1'b1, 24'd0, 24'd0, 1'b0}, 1'b1,
      '{16'sh0000, 16'd0, adsr_pkg::PH_SUSTAIN, 1'b0}},
    '{'{-16'sh8000, 1'b0, 24'hFFFFFF, 24'hFFFFFF, 1'b1}, 1'b1,
      '{16'sh0000, 16'd0, adsr_pkg::PH_DONE, 1'b1}},
    '{'{16'sh7FFF, 1'b1, 24'd0, 24'd0, 1'b1}, 1'b0, '0},
    '{'{-16'sh8000, 1'b1, 24'd50, 24'd0, 1'b0}, 1'b0, '0},
    '{'{16'sh1234, 1'b1, 24'd99, 24'd0, 1'b0}, 1'b0, '0},
    '{'{16'sh7FFF, 1'b1, 24'd100, 24'd0, 1'b1}, 1'b0, '0},
    '{'{-16'sh0001, 1'b1, 24'd150, 24'd0, 1'b0}, 1'b0, '0},
    '{'{16'sh7FFF, 1'b1, 24'd299, 24'd0, 1'b0}, 1'b0, '0},
    '{'{-16'sh8000, 1'b1, 24'd300, 24'd0, 1'b0}, 1'b0, '0},
    '{'{16'sh7FFF, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 1'b0}, 1'b0, '0},
    '{'{16'sh7FFF, 1'b0, 24'd10, 24'd0, 1'b0}, 1'b0, '0},
    '{'{-16'sh8000, 1'b0, 24'd10, 24'd199, 1'b1}, 1'b0, '0},
    '{'{16'sh5555, 1'b0, 24'd10, 24'd200, 1'b0}, 1'b0, '0},
    '{'{-16'sh2AAB, 1'b0, 24'd0, 24'hFFFFFF, 1'b1}, 1'b0, '0}
  };

  initial begin
    atk_len = 0; dec_len = 0; sus_reg = 0; rel_len = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    for (int i = 0; i < 2; i++) send_note(dir_rows[i].stim, dir_rows[i].res, dir_rows[i].known);
    set_envelope(100, 200, 16'h4000, 200);
    for (int i = 2; i < dir_rows.size(); i++)
      send_note(dir_rows[i].stim, dir_rows[i].res, dir_rows[i].known);
    // sustain above full scale, zero-length phases
    set_envelope(0, 0, 16'hFFFF, 0);
    for (int i = 2; i < dir_rows.size(); i++) send_note(dir_rows[i].stim, '0, 0);
    set_envelope(24'hFFFFFF, 24'hFFFFFF, 16'h8000, 24'hFFFFFF);
    for (int i = 2; i < 8; i++) send_note(dir_rows[i].stim, '0, 0);

    send_idle = 22; recv_idle = 75;
    for (int k = 0; k < 3; k++) begin
      set_envelope(rand_len(), rand_len(), 16'($urandom_range(0, 36000)), rand_len());
      random_phase(90);
    end
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      random_phase(60);
    join
    send_idle = 75; recv_idle = 22;
    for (int k = 0; k < 3; k++) begin
      set_envelope(rand_len(), rand_len(), 16'($urandom), rand_len());
      random_phase(90);
    end
    send_idle = 0; recv_idle = 0;
    for (int k = 0; k < 3; k++) begin
      set_envelope(rand_len(), rand_len(), 16'($urandom_range(0, 32768)), rand_len());
      random_phase(90);
    end

    drop_input();
    while (pending_gain.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

FILE: files.f
rtl/core/adsr_pkg.sv
rtl/core/adsr_div_cell.sv
rtl/core/adsr_phase_sel.sv
rtl/core/adsr_envelope_gain_core.sv
rtl/core/adsr_checker.sv
bench/tb_adsr_envelope_gain_core.sv
